// ===== rtl/core/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon geofence test.
// Used by pip_cell, point_in_polygon_test and pip_checker; no dependencies.
`default_nettype none

package pip_pkg;

    // Number of polygon corners, and so the number of edge cells (3 or 4).
    localparam int CORNERS = 4;

    // Configuration register file: x and y for four corners.
    localparam int NUM_CFG_REGS = 8;
    localparam int CFG_IDX_W    = 3;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Each edge cell has three register stages.
    localparam int CELL_STAGES = 3;
    localparam int LATENCY     = CELL_STAGES * CORNERS;

    // What one cell hands to the next: the point and the running parity.
    typedef struct packed {
        logic                      odd;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } token_t;

endpackage

`default_nettype wire

// ===== rtl/core/pip_cell.sv =====
// One edge cell of the ray-casting chain: tests one polygon edge and updates parity.
// Depends on pip_pkg for widths and the token type.
`default_nettype none

module pip_cell
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire pip_pkg::token_t                    in_tok,
    input  wire logic signed [pip_pkg::COORD_W-1:0] xi,
    input  wire logic signed [pip_pkg::COORD_W-1:0] yi,
    input  wire logic signed [pip_pkg::COORD_W-1:0] xj,
    input  wire logic signed [pip_pkg::COORD_W-1:0] yj,
    output logic                                    out_valid,
    output pip_pkg::token_t                         out_tok
);

    // Stage 1: differences and the span test.
    logic                              s1_valid_reg;
    pip_pkg::token_t                   s1_tok_reg;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dyp_reg, s1_dyp_next;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dxe_reg, s1_dxe_next;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dxp_reg, s1_dxp_next;
    logic signed [pip_pkg::DIFF_W-1:0] s1_dye_reg, s1_dye_next;
    logic                              s1_cross_reg, s1_cross_next;
    logic                              s1_dpos_reg, s1_dpos_next;

    // Stage 2: the two cross products.
    logic                              s2_valid_reg;
    pip_pkg::token_t                   s2_tok_reg;
    logic signed [pip_pkg::PROD_W-1:0] s2_lhs_reg, s2_lhs_next;
    logic signed [pip_pkg::PROD_W-1:0] s2_rhs_reg, s2_rhs_next;
    logic                              s2_cross_reg;
    logic                              s2_dpos_reg;

    // Stage 3: compare and toggle.
    logic                              s3_valid_reg;
    pip_pkg::token_t                   s3_tok_reg, s3_tok_next;
    logic                              left;

    always_comb
    begin
        s1_dyp_next   = pip_pkg::DIFF_W'(in_tok.py) - pip_pkg::DIFF_W'(yi);
        s1_dxe_next   = pip_pkg::DIFF_W'(xj) - pip_pkg::DIFF_W'(xi);
        s1_dxp_next   = pip_pkg::DIFF_W'(in_tok.px) - pip_pkg::DIFF_W'(xi);
        s1_dye_next   = pip_pkg::DIFF_W'(yj) - pip_pkg::DIFF_W'(yi);
        s1_cross_next = ((yi < in_tok.py) && (yj >= in_tok.py)) ||
                        ((yj < in_tok.py) && (yi >= in_tok.py));
        s1_dpos_next  = (yj > yi);
    end

    assign s2_lhs_next = s1_dyp_reg * s1_dxe_reg;
    assign s2_rhs_next = s1_dxp_reg * s1_dye_reg;

    // With the edge running upward the crossing lies left of the point when
    // lhs < rhs; a downward edge flips the inequality.
    assign left = s2_dpos_reg ? (s2_lhs_reg < s2_rhs_reg) : (s2_rhs_reg < s2_lhs_reg);

    always_comb
    begin
        s3_tok_next     = s2_tok_reg;
        s3_tok_next.odd = s2_tok_reg.odd ^ (s2_cross_reg & left);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tok_reg   <= in_tok;
        s1_dyp_reg   <= s1_dyp_next;
        s1_dxe_reg   <= s1_dxe_next;
        s1_dxp_reg   <= s1_dxp_next;
        s1_dye_reg   <= s1_dye_next;
        s1_cross_reg <= s1_cross_next;
        s1_dpos_reg  <= s1_dpos_next;

        s2_tok_reg   <= s1_tok_reg;
        s2_lhs_reg   <= s2_lhs_next;
        s2_rhs_reg   <= s2_rhs_next;
        s2_cross_reg <= s1_cross_reg;
        s2_dpos_reg  <= s1_dpos_reg;

        s3_tok_reg   <= s3_tok_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_tok   = s3_tok_reg;

endmodule

`default_nettype wire

// ===== rtl/core/point_in_polygon_test.sv =====
// Top level of the point-in-polygon geofence test: corner registers and a chain of edge cells.
// Depends on pip_pkg and pip_cell.
`default_nettype none

//  Channel      Handshake                 Payload
//  -----------  ------------------------  ------------------------------------
//  request in   start (accepted if !busy) point_x, point_y (signed, deg * 1e7)
//  result out   done (one-cycle strobe)   inside_res (1 = inside)
//  config       cfg_we                    cfg_index, cfg_wdata
//
// A request is taken in every cycle; busy is never raised. The result of a
// request passes, after it was accepted, through three register stages in
// each edge cell: differences, cross products, compare. Results come out in
// request order. The receiver cannot stall, so nothing is ever held back.
// Reset clears the pipeline valid bits and returns all corner registers to
// zero.

module point_in_polygon_test
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [pip_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [pip_pkg::COORD_W-1:0]   point_y,
    output logic                                      done,
    output logic                                      inside_res,
    input  wire logic                                 cfg_we,
    input  wire logic        [pip_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [pip_pkg::COORD_W-1:0]   cfg_wdata
);

    // Corner registers: even index holds x, odd index holds y.
    logic signed [pip_pkg::COORD_W-1:0] cfg_reg [pip_pkg::NUM_CFG_REGS];

    // Hand-off between cells: entry k feeds cell k, the last entry is the result.
    logic            chain_valid [pip_pkg::CORNERS+1];
    pip_pkg::token_t chain_tok   [pip_pkg::CORNERS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < pip_pkg::NUM_CFG_REGS; r++)
            begin
                cfg_reg[r] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // A fresh request enters the chain with even parity.
    assign chain_valid[0]   = start;
    assign chain_tok[0].odd = 1'b0;
    assign chain_tok[0].px  = point_x;
    assign chain_tok[0].py  = point_y;

    // Cell k tests the edge from corner k-1 to corner k; cell 0 closes the
    // polygon with the edge from the last corner.
    for (genvar k = 0; k < pip_pkg::CORNERS; k++)
    begin : g_cell
        localparam int J = (k == 0) ? pip_pkg::CORNERS - 1 : k - 1;

        pip_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_tok    (chain_tok[k]),
            .xi        (cfg_reg[2 * k]),
            .yi        (cfg_reg[2 * k + 1]),
            .xj        (cfg_reg[2 * J]),
            .yj        (cfg_reg[2 * J + 1]),
            .out_valid (chain_valid[k+1]),
            .out_tok   (chain_tok[k+1])
        );
    end

    // The chain is fully pipelined, so requests are never refused.
    assign busy       = 1'b0;
    assign done       = chain_valid[pip_pkg::CORNERS];
    assign inside_res = chain_tok[pip_pkg::CORNERS].odd;

endmodule

`default_nettype wire

// ===== rtl/core/pip_checker.sv =====
// Port-level checks for point_in_polygon_test, bound onto the top level.
// Depends on pip_pkg for the pipeline latency.
`default_nettype none

module pip_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // Every accepted request produces a result once it has passed the whole pipeline.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(pip_pkg::LATENCY) done)
        else $error("accepted request produced no result");

    // No result appears without a matching accepted request that entered the pipeline.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, pip_pkg::LATENCY))
        else $error("result without a matching request");

    // Reset empties the pipeline at once.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !done)
        else $error("result strobe during reset");

    // The pipeline never refuses a request.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire

// ===== tb/point_in_polygon_test_tb.sv =====
// Self-checking testbench for point_in_polygon_test, the ray-casting geofence block.
// Depends on pip_pkg for the coordinate width, corner count and pipeline latency.
// A scoreboard class predicts the inside bit of every accepted request.

module point_in_polygon_test_tb;

    import pip_pkg::*;

    // Corner registers in the order of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER0_X = 3'd0,
        REG_CORNER0_Y = 3'd1,
        REG_CORNER1_X = 3'd2,
        REG_CORNER1_Y = 3'd3,
        REG_CORNER2_X = 3'd4,
        REG_CORNER2_Y = 3'd5,
        REG_CORNER3_X = 3'd6,
        REG_CORNER3_Y = 3'd7
    } corner_reg_e;

    // Kinds of polygon used in the random part.
    typedef enum int {
        POLY_IN_RANGE,
        POLY_FULL_PATTERN,
        POLY_TINY,
        POLY_FLAT_EDGES,
        POLY_EXTREME
    } poly_kind_e;

    localparam int N_SETS        = 10;
    localparam int ITEMS_PER_SET = 125;
    localparam int CYCLE_LIMIT   = 200000;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam longint COORD_MAX = 64'sd2147483647;

    // Holds a copy of the corner registers and the queue of inside bits still
    // to come out of the block. Every request gets its bit predicted when it
    // is accepted; every done strobe is compared against the oldest one.
    class GeofenceScoreboard;
        logic [COORD_W-1:0] corner_regs [NUM_CFG_REGS];
        bit                 expected_inside [$];
        int                 mismatch_count;

        function new();
            foreach (corner_regs[k])
                corner_regs[k] = '0;
            mismatch_count = 0;
        endfunction

        function void set_reg(int idx, logic [COORD_W-1:0] value);
            corner_regs[idx] = value;
        endfunction

        // Exact ray cast: an edge counts when the point's y lies in its
        // half-open span, and toggles the parity when the edge passes strictly
        // to the left of the point. The division of the textbook form is
        // replaced by a cross-multiplication with the sign of the y step.
        function bit ray_cast_inside(logic signed [COORD_W-1:0] px,
                                     logic signed [COORD_W-1:0] py);
            logic signed [COORD_W-1:0] xi, yi, xj, yj;
            logic signed [COORD_W+1:0] dy, dx, ry, rx;
            logic signed [2*COORD_W+3:0] lhs, rhs;
            bit odd;
            bit left;
            int j;
            odd = 1'b0;
            j = CORNERS - 1;
            for (int i = 0; i < CORNERS; i++)
            begin
                xi = corner_regs[(2 * i) % NUM_CFG_REGS];
                yi = corner_regs[(2 * i + 1) % NUM_CFG_REGS];
                xj = corner_regs[(2 * j) % NUM_CFG_REGS];
                yj = corner_regs[(2 * j + 1) % NUM_CFG_REGS];
                if ((yi < py && yj >= py) || (yj < py && yi >= py))
                begin
                    dy  = yj - yi;
                    dx  = xj - xi;
                    ry  = py - yi;
                    rx  = px - xi;
                    lhs = ry * dx;
                    rhs = rx * dy;
                    left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
                    if (left)
                        odd = ~odd;
                end
                j = i;
            end
            return odd;
        endfunction

        function void note_request(logic signed [COORD_W-1:0] px,
                                   logic signed [COORD_W-1:0] py);
            expected_inside.push_back(ray_cast_inside(px, py));
        endfunction

        function void check_result(logic actual);
            bit want;
            if (expected_inside.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: inside_res with no request pending, expected none, actual %0b",
                         $time, actual);
            end
            else
            begin
                want = expected_inside.pop_front();
                if (actual !== want)
                begin
                    mismatch_count++;
                    $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                             $time, want, actual);
                end
            end
        endfunction

        function int pending();
            return expected_inside.size();
        endfunction
    endclass

    // Every input of the block has a known value from time zero. Reset
    // starts high so that its fall at time zero is seen by the block.
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b1;
    logic                      start     = 1'b0;
    logic signed [COORD_W-1:0] point_x   = '0;
    logic signed [COORD_W-1:0] point_y   = '0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [COORD_W-1:0]        cfg_wdata = '0;
    logic                      busy;
    logic                      done;
    logic                      inside_res;

    GeofenceScoreboard sb = new();

    // The polygon that the stimulus is about to load, or has loaded.
    logic signed [COORD_W-1:0] poly_x [4];
    logic signed [COORD_W-1:0] poly_y [4];

    int unsigned cycle_count = 0;

    point_in_polygon_test u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point_x    (point_x),
        .point_y    (point_y),
        .done       (done),
        .inside_res (inside_res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Sampling at the rising edge reads the values that were stable during
    // the cycle that the edge ends, because the block and the drivers below
    // only change their signals through nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(inside_res);
        if (rst_n && start && !busy)
            sb.note_request(point_x, point_y);
    end

    // Watchdog: a hung pipeline or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("point_in_polygon_test verification failed");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v < COORD_MIN)
            return COORD_MIN[COORD_W-1:0];
        if (v > COORD_MAX)
            return COORD_MAX[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    // Uniform value in [lo, hi]; the span may reach the whole 32-bit range.
    function automatic longint rand_between(longint lo, longint hi);
        longint unsigned r;
        r = {$urandom(), $urandom()};
        return lo + longint'(r % longint'(hi - lo + 1));
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_in_range();
        return clamp_coord(longint'($urandom_range(32'd3600000000)) - 64'sd1800000000);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_extreme();
        case ($urandom_range(3))
            0:       return COORD_MIN[COORD_W-1:0];
            1:       return COORD_MAX[COORD_W-1:0];
            2:       return -32'sd1800000000;
            default: return 32'sd1800000000;
        endcase
    endfunction

    // One request. The sender may idle first; start then stays high until the
    // request is taken, and is left high so that a back-to-back request does
    // not drop it for a cycle.
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        point_x <= x;
        point_y <= y;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Lowers start and waits until every predicted result has come out, plus
    // the pipeline depth, so that the block is idle afterwards.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    task automatic write_reg(input corner_reg_e idx, input logic [COORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_reg(int'(idx), value);
    endtask

    task automatic write_polygon();
        write_reg(REG_CORNER0_X, poly_x[0]);
        write_reg(REG_CORNER0_Y, poly_y[0]);
        write_reg(REG_CORNER1_X, poly_x[1]);
        write_reg(REG_CORNER1_Y, poly_y[1]);
        write_reg(REG_CORNER2_X, poly_x[2]);
        write_reg(REG_CORNER2_Y, poly_y[2]);
        write_reg(REG_CORNER3_X, poly_x[3]);
        write_reg(REG_CORNER3_Y, poly_y[3]);
        cfg_we <= 1'b0;
    endtask

    task automatic make_polygon(input poly_kind_e kind);
        logic signed [COORD_W-1:0] cx, cy;
        cx = clamp_coord(longint'(rand_in_range()) / 2);
        cy = clamp_coord(longint'(rand_in_range()) / 2);
        for (int k = 0; k < 4; k++)
        begin
            case (kind)
                POLY_IN_RANGE:
                begin
                    poly_x[k] = rand_in_range();
                    poly_y[k] = rand_in_range();
                end
                POLY_FULL_PATTERN:
                begin
                    poly_x[k] = $urandom();
                    poly_y[k] = $urandom();
                end
                POLY_TINY:
                begin
                    poly_x[k] = cx + $signed($urandom_range(2000)) - 1000;
                    poly_y[k] = cy + $signed($urandom_range(2000)) - 1000;
                end
                POLY_FLAT_EDGES:
                begin
                    poly_x[k] = rand_in_range();
                    poly_y[k] = (k < 2) ? cx : cy;
                end
                default:
                begin
                    poly_x[k] = rand_extreme();
                    poly_y[k] = rand_extreme();
                end
            endcase
        end
        // Now and then a repeated corner leaves an edge of zero length.
        if (kind == POLY_FLAT_EDGES && $urandom_range(1) == 1)
        begin
            poly_x[3] = poly_x[0];
            poly_y[3] = poly_y[0];
        end
    endtask

    // Most points fall in or near the bounding box of the polygon, a share of
    // them on a corner's y (the half-open span boundary) or x, some exactly
    // on a corner; the rest are any 32-bit pattern.
    task automatic next_point(output logic signed [COORD_W-1:0] x,
                              output logic signed [COORD_W-1:0] y);
        longint lo_x, hi_x, lo_y, hi_y, mx, my;
        int pick;
        int k;
        lo_x = poly_x[0];
        hi_x = poly_x[0];
        lo_y = poly_y[0];
        hi_y = poly_y[0];
        for (int c = 1; c < 4; c++)
        begin
            if (poly_x[c] < lo_x) lo_x = poly_x[c];
            if (poly_x[c] > hi_x) hi_x = poly_x[c];
            if (poly_y[c] < lo_y) lo_y = poly_y[c];
            if (poly_y[c] > hi_y) hi_y = poly_y[c];
        end
        mx = (hi_x - lo_x) / 4 + 2;
        my = (hi_y - lo_y) / 4 + 2;
        lo_x = clamp_coord(lo_x - mx);
        hi_x = clamp_coord(hi_x + mx);
        lo_y = clamp_coord(lo_y - my);
        hi_y = clamp_coord(hi_y + my);
        pick = $urandom_range(99);
        k = $urandom_range(3);
        if (pick < 15)
        begin
            x = $urandom();
            y = $urandom();
        end
        else
        begin
            x = COORD_W'(rand_between(lo_x, hi_x));
            y = COORD_W'(rand_between(lo_y, hi_y));
            if (pick < 30)
                y = poly_y[k];
            else if (pick < 38)
                x = poly_x[k];
            else if (pick < 42)
            begin
                x = poly_x[k];
                y = poly_y[k];
            end
        end
    endtask

    initial
    begin
        int idle_pct;
        logic signed [COORD_W-1:0] px, py;

        rst_n <= 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Right after reset every corner sits at the origin, so the polygon
        // is degenerate and nothing can be inside it.
        send_point(32'sd0, 32'sd0, 0);
        send_point(-32'sd1, 32'sd1, 0);
        wait_for_results();

        // A skewed quadrilateral spanning the whole legal range.
        poly_x[0] = -32'sd1800000000; poly_y[0] = -32'sd1800000000;
        poly_x[1] =  32'sd1800000000; poly_y[1] = -32'sd1200000000;
        poly_x[2] =  32'sd1500000000; poly_y[2] =  32'sd1800000000;
        poly_x[3] = -32'sd1700000000; poly_y[3] =  32'sd900000000;
        write_polygon();
        send_point(32'sd0, 32'sd0, 0);
        send_point(COORD_MIN[COORD_W-1:0], COORD_MIN[COORD_W-1:0], 0);
        send_point(COORD_MAX[COORD_W-1:0], COORD_MAX[COORD_W-1:0], 0);
        send_point(COORD_MIN[COORD_W-1:0], 32'sd0, 0);
        send_point(COORD_MAX[COORD_W-1:0], 32'sd0, 0);
        send_point(32'sd0, COORD_MIN[COORD_W-1:0], 0);
        send_point(32'sd0, COORD_MAX[COORD_W-1:0], 0);
        send_point(-32'sd1, -32'sd1, 0);
        // On the y of the lowest corner, the highest corner and a middle one.
        send_point(32'sd0, -32'sd1800000000, 0);
        send_point(32'sd0, 32'sd1800000000, 0);
        send_point(32'sd0, 32'sd900000000, 0);
        // Exactly on a corner, and exactly on the middle of the bottom edge.
        send_point(-32'sd1800000000, -32'sd1800000000, 0);
        send_point(32'sd0, -32'sd1500000000, 0);
        wait_for_results();

        // An axis-aligned square, whose top and bottom edges are horizontal
        // and so never count as crossed.
        poly_x[0] = -32'sd500; poly_y[0] = -32'sd500;
        poly_x[1] =  32'sd500; poly_y[1] = -32'sd500;
        poly_x[2] =  32'sd500; poly_y[2] =  32'sd500;
        poly_x[3] = -32'sd500; poly_y[3] =  32'sd500;
        write_polygon();
        send_point(32'sd0, -32'sd500, 0);
        send_point(32'sd0, 32'sd500, 0);
        send_point(-32'sd500, 32'sd0, 0);
        send_point(32'sd500, 32'sd0, 0);
        send_point(32'sd0, 32'sd0, 0);
        send_point(32'sd600, 32'sd0, 0);
        send_point(-32'sd600, 32'sd0, 0);

        // Random part: a fresh polygon per set, loaded only once the pipeline
        // has drained, with the sender's idling changing from set to set.
        for (int s = 0; s < N_SETS; s++)
        begin
            wait_for_results();
            make_polygon(poly_kind_e'(s % 5));
            write_polygon();
            case (s % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 59;
                2:       idle_pct = 0;
                default: idle_pct = 28;
            endcase
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                next_point(px, py);
                send_point(px, py, idle_pct);
            end
        end

        wait_for_results();
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("point_in_polygon_test verification clean");
        else
            $display("point_in_polygon_test verification failed");
        $finish;
    end

endmodule
